// ----- src/graph6_string_encoder_macros.svh -----
// Assertion macros shared by the graph6 encoder modules.
`ifndef GRAPH6_STRING_ENCODER_MACROS_SVH
`define GRAPH6_STRING_ENCODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GSE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("graph6 encoder check failed");

// Next-cycle implication, disabled during reset.
`define GSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("graph6 encoder check failed");

`endif

// ----- src/gse_pkg.sv -----
// Shared types and constants of the graph6 encoder.
package gse_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int ROW_W = 64;
	localparam int CNT_W = 7;
	localparam int CHAR_W = 7;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CHAR_W-1:0] G6_BIAS = 7'd63;
	localparam logic [CHAR_W-1:0] G6_LONG_MARK = 7'd126;
	localparam logic [CNT_W-1:0] G6_SHORT_MAX = 7'd62;
	localparam logic [2:0] G6_GROUP = 3'd6;

	// One classified row handed from the front to the back.
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [CNT_W-1:0] nbits;
		logic [CNT_W-1:0] n;
		logic first;
		logic last;
	} row_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HEAD,
		ST_PACK
	} back_state_t;

endpackage

// ----- src/gse_front.sv -----
// Front end: accepts rows, tracks the row index and classifies each row.
module gse_front #(
	parameter int MAX_VERTICES = gse_pkg::MAX_VERTICES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [gse_pkg::CNT_W-1:0] vertex_count,
	input  logic in_valid,
	output logic in_stall,
	input  logic [gse_pkg::ROW_W-1:0] row_bits,
	input  logic q_full,
	output logic push,
	output gse_pkg::row_entry_t push_entry
);

	logic [gse_pkg::CNT_W-1:0] vcount_q;
	logic [gse_pkg::CNT_W-1:0] row_index_q;
	logic [gse_pkg::CNT_W-1:0] n_eff;
	logic [gse_pkg::CNT_W-1:0] idx;
	logic is_last;

	// Clamp the vertex count into its legal range
	always_comb begin
		if (vcount_q == '0) begin
			n_eff = gse_pkg::CNT_W'(1);
		end else if (vcount_q > gse_pkg::CNT_W'(MAX_VERTICES)) begin
			n_eff = gse_pkg::CNT_W'(MAX_VERTICES);
		end else begin
			n_eff = vcount_q;
		end
	end

	// Restart at row 0 once the index has run past the count
	assign idx = (row_index_q >= n_eff) ? '0 : row_index_q;
	assign is_last = ({1'b0, idx} + 8'd1) >= {1'b0, n_eff};

	assign in_stall = q_full;
	assign push = in_valid && !q_full;

	always_comb begin
		push_entry.row = row_bits;
		push_entry.nbits = idx;
		push_entry.n = n_eff;
		push_entry.first = (idx == '0);
		push_entry.last = is_last;
	end

	// Hold the count; advance the row index on each transfer, drop it on a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= gse_pkg::CNT_W'(1);
			row_index_q <= '0;
		end else if (cfg_we) begin
			vcount_q <= vertex_count;
			row_index_q <= '0;
		end else if (push) begin
			row_index_q <= is_last ? '0 : (idx + gse_pkg::CNT_W'(1));
		end
	end

endmodule

// ----- src/gse_fifo.sv -----
// Short queue of classified rows between the front and the back.
`include "graph6_string_encoder_macros.svh"

module gse_fifo #(
	parameter int DEPTH = gse_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  gse_pkg::row_entry_t push_entry,
	output logic full,
	input  logic pop,
	output logic q_valid,
	output gse_pkg::row_entry_t q_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	gse_pkg::row_entry_t slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_pop;

	assign full = (count_q == CNT_W'(DEPTH));
	assign q_valid = (count_q != '0);
	assign do_pop = pop && q_valid;
	assign q_entry = slots_q[rd_ptr_q];

	// Store incoming rows
	always_ff @(posedge clk) begin
		if (push && !full) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push && !full, do_pop})
				2'b10: count_q <= count_q + CNT_W'(1);
				2'b01: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`GSE_ASSERT_NOW(a_no_push_full, clk, arst_n, full, !(push && !full) && count_q == CNT_W'(DEPTH))
	`GSE_ASSERT_NEXT(a_push_fills, clk, arst_n, push && !full && !do_pop, count_q != '0)

endmodule

// ----- src/gse_back.sv -----
// Back end: emits the header, packs row bits into 6-bit groups, holds the output.
`include "graph6_string_encoder_macros.svh"

module gse_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  gse_pkg::row_entry_t q_entry,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output logic [gse_pkg::CHAR_W-1:0] out_char,
	output logic last_char
);

	gse_pkg::back_state_t state_q;
	gse_pkg::back_state_t state_d;

	logic [gse_pkg::ROW_W-1:0] row_q;
	logic [gse_pkg::CNT_W-1:0] rem_q;
	logic [gse_pkg::CNT_W-1:0] n_q;
	logic last_q;
	logic [1:0] hdr_q;
	logic [4:0] carry_q;
	logic [2:0] cc_q;

	logic out_valid_q;
	logic [gse_pkg::CHAR_W-1:0] out_char_q;
	logic last_char_q;

	logic step_en;
	logic emit;
	logic [gse_pkg::CHAR_W-1:0] emit_char;
	logic emit_last;

	logic long_hdr;
	logic hdr_done;
	logic [gse_pkg::CHAR_W-1:0] hdr_char;
	logic [2:0] take;
	logic full_grp;
	logic [2:0] total;
	logic [5:0] comb_grp;
	logic [5:0] pad_mask;
	logic [4:0] carry_new;
	logic [5:0] row_lo;

	assign step_en = !out_valid_q || !out_stall;

	// Header characters
	assign long_hdr = n_q > gse_pkg::G6_SHORT_MAX;
	assign hdr_done = !long_hdr || (hdr_q == 2'd3);
	always_comb begin
		case (hdr_q)
			2'd0: hdr_char = long_hdr ? gse_pkg::G6_LONG_MARK : n_q + gse_pkg::G6_BIAS;
			2'd1: hdr_char = gse_pkg::G6_BIAS;
			2'd2: hdr_char = gse_pkg::G6_BIAS + gse_pkg::CHAR_W'(n_q[gse_pkg::CNT_W-1:6]);
			2'd3: hdr_char = gse_pkg::G6_BIAS + gse_pkg::CHAR_W'(n_q[5:0]);
			default: hdr_char = gse_pkg::G6_BIAS;
		endcase
	end

	// Merge carried bits with the next row bits, first bit at the MSB
	assign row_lo = row_q[5:0];
	always_comb begin
		logic [2:0] ci;
		logic [2:0] ri;
		comb_grp = '0;
		for (int p = 0; p < 6; p++) begin
			ci = 3'(cc_q - 3'(p) - 3'd1);
			ri = 3'(3'(p) - cc_q);
			if (3'(p) < cc_q) begin
				comb_grp[5-p] = carry_q[ci];
			end else begin
				comb_grp[5-p] = row_lo[ri];
			end
		end
	end

	assign take = gse_pkg::G6_GROUP - cc_q;
	assign full_grp = rem_q >= gse_pkg::CNT_W'(take);
	assign total = cc_q + rem_q[2:0];
	assign pad_mask = 6'h3F << (gse_pkg::G6_GROUP - total);
	assign carry_new = 5'(comb_grp >> (gse_pkg::G6_GROUP - total));

	// Next state and emitted character
	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		emit = 1'b0;
		emit_char = gse_pkg::G6_BIAS;
		emit_last = 1'b0;
		case (state_q)
			gse_pkg::ST_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					state_d = q_entry.first ? gse_pkg::ST_HEAD : gse_pkg::ST_PACK;
				end
			end
			gse_pkg::ST_HEAD: begin
				if (step_en) begin
					emit = 1'b1;
					emit_char = hdr_char;
					if (hdr_done) begin
						emit_last = last_q;
						state_d = gse_pkg::ST_IDLE;
					end
				end
			end
			gse_pkg::ST_PACK: begin
				if (step_en) begin
					if (full_grp) begin
						emit = 1'b1;
						emit_char = gse_pkg::CHAR_W'(comb_grp) + gse_pkg::G6_BIAS;
						emit_last = last_q && (rem_q == gse_pkg::CNT_W'(take));
						if (rem_q == gse_pkg::CNT_W'(take)) begin
							state_d = gse_pkg::ST_IDLE;
						end
					end else if (last_q) begin
						emit = 1'b1;
						emit_char = gse_pkg::CHAR_W'(comb_grp & pad_mask) + gse_pkg::G6_BIAS;
						emit_last = 1'b1;
						state_d = gse_pkg::ST_IDLE;
					end else begin
						state_d = gse_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = gse_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gse_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Row payload: load on pop, shift out consumed bits
	always_ff @(posedge clk) begin
		if (pop) begin
			row_q <= q_entry.row;
			rem_q <= q_entry.nbits;
			n_q <= q_entry.n;
			last_q <= q_entry.last;
		end else if (state_q == gse_pkg::ST_PACK && step_en && full_grp) begin
			row_q <= row_q >> take;
			rem_q <= rem_q - gse_pkg::CNT_W'(take);
		end
	end

	// Carry and header position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= '0;
			carry_q <= '0;
			cc_q <= '0;
		end else if (pop) begin
			hdr_q <= '0;
			if (q_entry.first) begin
				carry_q <= '0;
				cc_q <= '0;
			end
		end else if (state_q == gse_pkg::ST_HEAD && step_en) begin
			hdr_q <= hdr_q + 2'd1;
		end else if (state_q == gse_pkg::ST_PACK && step_en) begin
			if (full_grp || last_q) begin
				carry_q <= '0;
				cc_q <= '0;
			end else begin
				carry_q <= carry_new;
				cc_q <= total;
			end
		end
	end

	// Output register: load on emit, drop after transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= emit_char;
			last_char_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char = out_char_q;
	assign last_char = last_char_q;

	`GSE_ASSERT_NOW(a_head_no_bits, clk, arst_n, state_q == gse_pkg::ST_HEAD, rem_q == '0)
	`GSE_ASSERT_NEXT(a_last_goes_idle, clk, arst_n, emit && emit_last, state_q == gse_pkg::ST_IDLE)
	`GSE_ASSERT_NEXT(a_first_clears, clk, arst_n, pop && q_entry.first, cc_q == '0 && carry_q == '0)

endmodule

// ----- src/graph6_string_encoder.sv -----
// Top level of the graph6 string encoder.
//
// Input channel (in_valid / in_stall / row_bits): one adjacency row per
// transfer, row 0 first; bit j set means an edge to vertex j, and only
// bits below the row number are used. Output channel (out_valid /
// out_stall / out_char / last_char): one graph6 character per transfer,
// last_char marks the final character of the graph string.
// cfg_we / vertex_count set the vertex count n and restart the graph.
//
// Each row leaves the queue before the packer starts on it; bits that do
// not fill a group at the end of a non-final row carry into the next row.
// The header adds one (n <= 62) or four characters; the bit packer emits
// one 6-bit group per cycle while the receiver does not stall, shifting
// up to six row bits at a time. A row passes the queue, the back-end state
// register and the output register before its first character is valid.
// A two-entry row queue lets the input transfer while the packer works.
// Reset empties the queue and output register and sets n to 1. When the
// receiver stalls, the output character holds and the packer waits.
module graph6_string_encoder #(
	parameter int MAX_VERTICES = gse_pkg::MAX_VERTICES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [gse_pkg::CNT_W-1:0] vertex_count,
	input  logic in_valid,
	output logic in_stall,
	input  logic [gse_pkg::ROW_W-1:0] row_bits,
	output logic out_valid,
	input  logic out_stall,
	output logic [gse_pkg::CHAR_W-1:0] out_char,
	output logic last_char
);

	logic q_full;
	logic push;
	logic pop;
	logic q_valid;
	gse_pkg::row_entry_t push_entry;
	gse_pkg::row_entry_t q_entry;

	gse_front #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.vertex_count(vertex_count),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.row_bits(row_bits),
		.q_full(q_full),
		.push(push),
		.push_entry(push_entry)
	);

	gse_fifo #(
		.DEPTH(gse_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.full(q_full),
		.pop(pop),
		.q_valid(q_valid),
		.q_entry(q_entry)
	);

	gse_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_entry(q_entry),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.last_char(last_char)
	);

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the graph6 string encoder.
`timescale 1ns / 1ps

module testbench;

	localparam int RANDOM_ROWS = 160;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [gse_pkg::CHAR_W-1:0] ch;
		logic last;
	} g6_char_t;

	typedef enum logic {
		STEP_ROW,
		STEP_CFG
	} step_kind_t;

	typedef struct packed {
		step_kind_t kind;
		logic [gse_pkg::ROW_W-1:0] value;
		logic typed;
		g6_char_t known;
	} stim_step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [gse_pkg::CNT_W-1:0] vertex_count = 7'd1;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [gse_pkg::ROW_W-1:0] row_bits = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [gse_pkg::CHAR_W-1:0] out_char;
	logic last_char;

	// Encoder state mirrored by the predictor
	int eff_count = 1;
	int next_row = 0;
	logic [5:0] pend_bits = '0;
	int pend_n = 0;

	g6_char_t expected_chars[$];
	int errors = 0;
	int cycles = 0;
	int random_rows = 0;
	bit src_calm = 1'b0;
	bit sink_calm = 1'b0;
	int sink_wait = 0;

	stim_step_t plan [25];

	graph6_string_encoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.vertex_count(vertex_count),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.row_bits(row_bits),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.last_char(last_char)
	);

	always #6 clk = ~clk;

	function automatic void add_char(input logic [gse_pkg::CHAR_W-1:0] c);
		g6_char_t item;
		item.ch = c;
		item.last = 1'b0;
		expected_chars.push_back(item);
	endfunction

	// Compute the characters one accepted row produces and queue them
	task automatic encode_row(input logic [gse_pkg::ROW_W-1:0] row);
		int first;
		g6_char_t tail;
		first = expected_chars.size();
		if (next_row >= eff_count) begin
			next_row = 0;
		end
		// emit the size header on row 0
		if (next_row == 0) begin
			pend_bits = '0;
			pend_n = 0;
			if (eff_count <= gse_pkg::G6_SHORT_MAX) begin
				add_char(gse_pkg::G6_BIAS + 7'(eff_count));
			end else begin
				add_char(gse_pkg::G6_LONG_MARK);
				add_char(gse_pkg::G6_BIAS + 7'((eff_count >> 12) & 63));
				add_char(gse_pkg::G6_BIAS + 7'((eff_count >> 6) & 63));
				add_char(gse_pkg::G6_BIAS + 7'(eff_count & 63));
			end
		end
		// pack the lower-triangle bits MSB-first into 6-bit groups
		for (int j = 0; j < next_row; j++) begin
			pend_bits = {pend_bits[4:0], row[j]};
			pend_n++;
			if (pend_n == gse_pkg::G6_GROUP) begin
				add_char(gse_pkg::G6_BIAS + {1'b0, pend_bits});
				pend_bits = '0;
				pend_n = 0;
			end
		end
		// flush the partial group and mark the end of the string on the last row
		if (next_row + 1 >= eff_count) begin
			if (pend_n != 0) begin
				add_char(gse_pkg::G6_BIAS + {1'b0, 6'(pend_bits << (6 - pend_n))});
			end
			if (expected_chars.size() > first) begin
				tail = expected_chars.pop_back();
				tail.last = 1'b1;
				expected_chars.push_back(tail);
			end
			next_row = 0;
			pend_bits = '0;
			pend_n = 0;
		end else begin
			next_row++;
		end
	endtask

	// Wait for the encoder to go quiet, then write the vertex count
	task automatic write_count(input logic [gse_pkg::CNT_W-1:0] v);
		in_valid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		vertex_count <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (v == 0) begin
			eff_count = 1;
		end else if (v > gse_pkg::MAX_VERTICES_DEF) begin
			eff_count = gse_pkg::MAX_VERTICES_DEF;
		end else begin
			eff_count = v;
		end
		next_row = 0;
		pend_bits = '0;
		pend_n = 0;
	endtask

	// Present one row, hold it until the transfer, then record its characters
	task automatic send_row(input logic [gse_pkg::ROW_W-1:0] r, input logic typed,
			input g6_char_t known);
		int gap;
		int mark;
		gap = src_calm ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		row_bits <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		mark = expected_chars.size();
		encode_row(r);
		// typed rows replace the computed characters with the known one
		if (typed) begin
			while (expected_chars.size() > mark) void'(expected_chars.pop_back());
			expected_chars.push_back(known);
		end
	endtask

	function automatic logic [gse_pkg::ROW_W-1:0] pick_row();
		case ($urandom_range(0, 9))
			0: pick_row = '0;
			1: pick_row = '1;
			2: pick_row = 64'd1 << $urandom_range(0, 63);
			default: pick_row = {$urandom, $urandom};
		endcase
	endfunction

	// Check each output transfer and draw the next stall
	always @(posedge clk) begin : sink
		g6_char_t want;
		int hold;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected char: expected none, actual %0d last %0b",
					$time, out_char, last_char);
				errors++;
			end else begin
				want = expected_chars.pop_front();
				if (out_char !== want.ch) begin
					$display("%0t: out_char mismatch: expected %0d, actual %0d",
						$time, want.ch, out_char);
					errors++;
				end
				if (last_char !== want.last) begin
					$display("%0t: last_char mismatch: expected %0b, actual %0b",
						$time, want.last, last_char);
					errors++;
				end
			end
			if ($urandom_range(0, 29) == 0) sink_calm <= !sink_calm;
			hold = sink_calm ? 0 : $urandom_range(0, 12);
			sink_wait <= hold;
			out_stall <= (hold != 0);
		end else if (sink_wait != 0) begin
			sink_wait <= sink_wait - 1;
			out_stall <= (sink_wait > 1);
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	initial begin
		int pick;
		int v;
		int graphs;
		plan = '{
			'{STEP_ROW, 64'd0, 1'b1, '{7'd64, 1'b1}},   // single vertex after reset
			'{STEP_CFG, 64'd0, 1'b0, '{7'd0, 1'b0}},    // zero count taken as one
			'{STEP_ROW, '1, 1'b1, '{7'd64, 1'b1}},
			'{STEP_CFG, 64'd2, 1'b0, '{7'd0, 1'b0}},
			'{STEP_ROW, '1, 1'b1, '{7'd65, 1'b0}},
			'{STEP_ROW, '1, 1'b1, '{7'd95, 1'b1}},      // one edge, padded group
			'{STEP_CFG, 64'd3, 1'b0, '{7'd0, 1'b0}},
			'{STEP_ROW, 64'd0, 1'b1, '{7'd66, 1'b0}},
			'{STEP_ROW, 64'd0, 1'b0, '{7'd0, 1'b0}},    // row with no character
			'{STEP_ROW, 64'd0, 1'b1, '{7'd63, 1'b1}},
			'{STEP_CFG, 64'd62, 1'b0, '{7'd0, 1'b0}},   // largest short header
			'{STEP_ROW, '1, 1'b1, '{7'd125, 1'b0}},
			'{STEP_ROW, '1, 1'b0, '{7'd0, 1'b0}},
			'{STEP_ROW, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '{7'd0, 1'b0}},
			'{STEP_CFG, 64'd63, 1'b0, '{7'd0, 1'b0}},   // long header, graph cut short
			'{STEP_ROW, '1, 1'b0, '{7'd0, 1'b0}},
			'{STEP_ROW, '1, 1'b0, '{7'd0, 1'b0}},
			'{STEP_CFG, 64'd127, 1'b0, '{7'd0, 1'b0}},  // above the maximum
			'{STEP_ROW, 64'd0, 1'b0, '{7'd0, 1'b0}},
			'{STEP_ROW, '1, 1'b0, '{7'd0, 1'b0}},
			'{STEP_CFG, 64'd65, 1'b0, '{7'd0, 1'b0}},
			'{STEP_ROW, '1, 1'b0, '{7'd0, 1'b0}},
			'{STEP_CFG, 64'd64, 1'b0, '{7'd0, 1'b0}},
			'{STEP_ROW, 64'h8000_0000_0000_0000, 1'b0, '{7'd0, 1'b0}},
			'{STEP_ROW, '1, 1'b0, '{7'd0, 1'b0}}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		for (int k = 0; k < $size(plan); k++) begin
			if (plan[k].kind == STEP_CFG) begin
				write_count(plan[k].value[gse_pkg::CNT_W-1:0]);
			end else begin
				send_row(plan[k].value, plan[k].typed, plan[k].known);
			end
		end

		// Random phases: whole graphs at a random count, sometimes a cut-off graph
		while (random_rows < RANDOM_ROWS) begin
			pick = $urandom_range(0, 19);
			case (pick)
				0: v = 0;
				1: v = $urandom_range(65, 127);
				2: v = $urandom_range(62, 64);
				3: v = $urandom_range(13, 61);
				default: v = $urandom_range(1, 12);
			endcase
			write_count(7'(v));
			src_calm = ($urandom_range(0, 3) == 0);
			graphs = (eff_count > 16) ? 1 : $urandom_range(1, 3);
			repeat (graphs) begin
				for (int r = 0; r < eff_count; r++) begin
					send_row(pick_row(), 1'b0, '0);
					random_rows++;
				end
			end
			if (eff_count > 1 && $urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, eff_count - 1)) begin
					send_row(pick_row(), 1'b0, '0);
					random_rows++;
				end
			end
		end

		// Drain the outstanding characters
		in_valid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
